// ===== hw/rtl/aea_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and constant log2 / exp2 tables for the auto-exposure adapter.
package aea_pkg;

    localparam int MIDDLE_GREY = 11796;
    localparam int TABLE_BITS  = 8;
    localparam int LOG_SIZE    = 1 << TABLE_BITS;
    localparam int LOG_W       = 9;   // table entries reach 255
    localparam int LG_W        = 14;  // p*256 + entry, p <= 31
    localparam int EXP_SIZE    = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_UP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DOWN   = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [31:0] luma;
        logic [15:0] dt;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] total_ev;
        logic [15:0]        mult_fraction;
        logic signed [7:0]  mult_shift;
    } out_item_t;

    typedef struct packed {
        logic               auto_enable;
        logic signed [15:0] ev_offset;
        logic signed [15:0] ev_min;
        logic signed [15:0] ev_max;
        logic [31:0]        luma_min;
        logic [31:0]        luma_max;
        logic [15:0]        rate_up;
        logic [15:0]        rate_down;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        auto_enable: 1'b1,
        ev_offset:   16'sd0,
        ev_min:      -16'sd4096,
        ev_max:      16'sd4096,
        luma_min:    32'd66,
        luma_max:    32'd6553600,
        rate_up:     16'd768,
        rate_down:   16'd256
    };

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic prep;
        logic eval;
        logic apply;
        logic log_sum;
        logic set_target;
        logic total;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
    } sts_t;

    // log2(1 + i/2^TABLE_BITS) in Q.8 by repeated squaring in Q2.30
    function automatic logic [LOG_W-1:0] log_entry(input int unsigned i);
        logic [63:0] m;
        logic [31:0] frac;
        m    = (64'd1 << 30) + (64'(i) << (30 - TABLE_BITS));
        frac = '0;
        for (int k = 0; k < 16; k++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 32'd1;
                m    = m >> 1;
            end
        end
        return LOG_W'((frac + 32'd128) >> 8);
    endfunction

    typedef logic [LOG_SIZE-1:0][LOG_W-1:0] log_table_t;

    function automatic log_table_t build_log_table();
        log_table_t t;
        for (int i = 0; i < LOG_SIZE; i++) begin
            t[i] = log_entry(i);
        end
        return t;
    endfunction

    localparam log_table_t LOG_TABLE = build_log_table();

    function automatic logic [LG_W-1:0] log2_const(input logic [31:0] v);
        int unsigned p;
        logic [31:0] norm;
        p = 0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) p = i;
        end
        norm = v << (31 - p);
        return LG_W'(p * 256) + LG_W'(LOG_TABLE[norm[30 -: TABLE_BITS]]);
    endfunction

    localparam logic [LG_W-1:0] LOG_GREY = log2_const(32'(MIDDLE_GREY));

    // 2^(1/2^(k+1)) in Q2.30
    function automatic logic [31:0] exp_root(input int k);
        case (k)
            0:       return 32'd1518500250;
            1:       return 32'd1276901417;
            2:       return 32'd1170923762;
            3:       return 32'd1121280436;
            4:       return 32'd1097253708;
            5:       return 32'd1085434106;
            6:       return 32'd1079572136;
            default: return 32'd1076653033;
        endcase
    endfunction

    function automatic logic [15:0] exp_entry(input int unsigned f);
        logic [63:0] acc;
        logic [63:0] r;
        acc = 64'd1 << 30;
        for (int k = 0; k < 8; k++) begin
            if (((f >> (7 - k)) & 1) != 0) begin
                acc = (acc * 64'(exp_root(k)) + (64'd1 << 29)) >> 30;
            end
        end
        r = (acc + (64'd1 << 14)) >> 15;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    typedef logic [EXP_SIZE-1:0][15:0] exp_table_t;

    function automatic exp_table_t build_exp_table();
        exp_table_t t;
        for (int i = 0; i < EXP_SIZE; i++) begin
            t[i] = exp_entry(i);
        end
        return t;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

    // lower limit tested first, so with min > max the upper limit wins above it
    function automatic logic signed [15:0] clamp_ev(
        input logic signed [17:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        if (v < 18'(lo)) begin
            return lo;
        end else if (v > 18'(hi)) begin
            return hi;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

// ===== hw/rtl/aea_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file for the auto-exposure adapter.
module aea_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aea_pkg::CFG_DATA_W-1:0]  cfg_data,
    output aea_pkg::cfg_t                   cfg,
    output logic                            cfg_clear
);
    import aea_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    // disabling wipes both adaptation levels
    assign cfg_clear = cfg_valid && (cfg_index == CFG_AUTO_ENABLE) && !cfg_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AUTO_ENABLE: cfg_reg.auto_enable <= cfg_data[0];
                CFG_EV_OFFSET:   cfg_reg.ev_offset   <= cfg_data[15:0];
                CFG_EV_MIN:      cfg_reg.ev_min      <= cfg_data[15:0];
                CFG_EV_MAX:      cfg_reg.ev_max      <= cfg_data[15:0];
                CFG_LUMA_MIN:    cfg_reg.luma_min    <= cfg_data[31:0];
                CFG_LUMA_MAX:    cfg_reg.luma_max    <= cfg_data[31:0];
                CFG_RATE_UP:     cfg_reg.rate_up     <= cfg_data[15:0];
                CFG_RATE_DOWN:   cfg_reg.rate_down   <= cfg_data[15:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/aea_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine and output valid for the auto-exposure adapter.
module aea_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  aea_pkg::sts_t sts,
    output aea_pkg::cmd_t cmd
);
    import aea_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_LOGSUM = 3'd4;
    localparam logic [2:0] ST_TARGET = 3'd5;
    localparam logic [2:0] ST_TOTAL  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = sts.is_tick ? ST_TOTAL : ST_LOGSUM;
            end
            ST_LOGSUM:
            begin
                cmd.log_sum = 1'b1;
                state_next  = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.set_target = 1'b1;
                state_next     = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                cmd.total  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/aea_dp.sv =====
`timescale 1ns / 1ps
// Datapath: luma clamp, log2, target and adapted levels, total EV and exp2 split.
module aea_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  aea_pkg::cfg_t      cfg,
    input  logic               cfg_clear,
    input  aea_pkg::cmd_t      cmd,
    output aea_pkg::sts_t      sts,
    input  aea_pkg::in_item_t  in_item,
    output aea_pkg::out_item_t out_item
);
    import aea_pkg::*;

    in_item_t                item_reg;
    logic [31:0]             luma_reg;
    logic signed [16:0]      diff_reg;
    logic [31:0]             step_reg;
    logic [4:0]              lod_reg;
    logic signed [17:0]      lvl_reg;
    logic                    hold_reg;
    logic [TABLE_BITS-1:0]   idx_reg;
    logic [LG_W-1:0]         lg_reg;
    logic signed [15:0]      target_reg;
    logic signed [15:0]      adapted_reg;
    logic signed [15:0]      total_reg;
    out_item_t               out_reg;

    logic [31:0]             luma_c;
    logic signed [16:0]      diff_c;
    logic                    rise_c;
    logic [15:0]             rate_c;
    logic [31:0]             step_c;
    logic                    zero_e;
    logic                    rise_e;
    logic [16:0]             mag_e;
    logic [31:0]             thr_e;
    logic                    snap_e;
    logic signed [17:0]      slew_e;
    logic signed [17:0]      adapted_ext;
    logic signed [17:0]      lvl_c;
    logic [4:0]              lod_c;
    logic [31:0]             norm_c;
    logic [LG_W-1:0]         lg_c;
    logic signed [15:0]      tgt_raw;
    logic signed [15:0]      adapted_c;
    logic signed [17:0]      sum_c;

    assign sts.is_tick = item_reg.kind;
    assign out_item    = out_reg;

    // measure: luma clamp, lower limit first
    always_comb
    begin
        if (item_reg.luma < cfg.luma_min)
        begin
            luma_c = cfg.luma_min;
        end
        else if (item_reg.luma > cfg.luma_max)
        begin
            luma_c = cfg.luma_max;
        end
        else
        begin
            luma_c = item_reg.luma;
        end
    end

    // tick: difference and rate*dt (Q.20)
    assign diff_c = 17'(target_reg) - 17'(adapted_reg);
    assign rise_c = !diff_c[16] && (diff_c != '0);
    assign rate_c = rise_c ? cfg.rate_up : cfg.rate_down;
    assign step_c = 32'(rate_c) * 32'(item_reg.dt);

    // tick: snap test and slew
    assign zero_e      = (diff_reg == '0);
    assign rise_e      = !diff_reg[16] && !zero_e;
    assign mag_e       = diff_reg[16] ? 17'(-diff_reg) : 17'(diff_reg);
    assign thr_e       = {3'b000, mag_e, 12'h000};
    assign snap_e      = zero_e || (step_reg >= thr_e);
    // below the snap point the step is under |diff|, so 16 bits suffice
    assign slew_e      = $signed({2'b00, step_reg[27:12]});
    assign adapted_ext = 18'(adapted_reg);
    assign lvl_c       = snap_e ? 18'(target_reg)
                       : (rise_e ? adapted_ext + slew_e : adapted_ext - slew_e);

    // leading-one position; zero reads as position 0
    always_comb
    begin
        lod_c = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (luma_reg[i]) lod_c = 5'(i);
        end
    end

    assign norm_c = luma_reg << (5'd31 - lod_reg);
    assign lg_c   = LG_W'({lod_reg, 8'h00}) + LG_W'(LOG_TABLE[idx_reg]);
    assign tgt_raw = $signed(16'(LOG_GREY)) - $signed(16'(lg_reg));

    always_comb
    begin
        if (!cfg.auto_enable)
        begin
            adapted_c = '0;
        end
        else if (hold_reg)
        begin
            adapted_c = lvl_reg[15:0];  // already equal to target
        end
        else
        begin
            adapted_c = clamp_ev(lvl_reg, cfg.ev_min, cfg.ev_max);
        end
    end

    assign sum_c = 18'(cfg.ev_offset) + (cfg.auto_enable ? 18'(adapted_reg) : 18'sd0);

    // adaptation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            adapted_reg <= '0;
        end
        else if (cfg_clear)
        begin
            target_reg  <= '0;
            adapted_reg <= '0;
        end
        else
        begin
            if (cmd.set_target)
            begin
                target_reg <= cfg.auto_enable
                            ? clamp_ev(18'(tgt_raw), cfg.ev_min, cfg.ev_max) : 16'sd0;
            end
            if (cmd.apply && item_reg.kind)
            begin
                adapted_reg <= adapted_c;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.prep)
        begin
            luma_reg <= luma_c;
            diff_reg <= diff_c;
            step_reg <= step_c;
        end
        if (cmd.eval)
        begin
            lod_reg  <= lod_c;
            lvl_reg  <= lvl_c;
            hold_reg <= zero_e;
        end
        if (cmd.apply)
        begin
            idx_reg <= norm_c[30 -: TABLE_BITS];
        end
        if (cmd.log_sum)
        begin
            lg_reg <= lg_c;
        end
        if (cmd.total)
        begin
            total_reg <= clamp_ev(sum_c, cfg.ev_min, cfg.ev_max);
        end
        if (cmd.load_out)
        begin
            out_reg.total_ev      <= total_reg;
            out_reg.mult_fraction <= EXP_TABLE[total_reg[7:0]];
            out_reg.mult_shift    <= total_reg[15:8];
        end
    end

endmodule

// ===== hw/rtl/auto_exposure_adapter.sv =====
`timescale 1ns / 1ps
// Top level of the auto-exposure adapter: config registers, controller and datapath.
//
//  channel   signals                              direction
//  -------   ----------------------------------   -------------------------
//  in        in_valid, in_stall, in_item          item in, stall out
//  out       out_valid, out_stall, out_item       item out, stall in
//  cfg       cfg_valid, cfg_ready, cfg_index,     write in, ready always high
//            cfg_data
//
// One item is in flight at a time. A measure item passes through prep, eval,
// apply, log-sum, target, total and out states before its result is valid; a
// tick item skips log-sum and target. The length is set by the log path:
// leading-one detect, normalizing shift, table add and target clamp each take
// one stage. Reset (rst_n, async) loads the register defaults and zeroes both
// EV levels. The result sits in an output register, so a stalled result does not
// hold off the next input item; only the final stage waits for a free register.
module auto_exposure_adapter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  aea_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output aea_pkg::out_item_t             out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aea_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aea_pkg::*;

    cfg_t cfg;
    logic cfg_clear;
    cmd_t cmd;
    sts_t sts;

    // register file; a write of 0 to auto_enable also clears the levels
    aea_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    // sequencer: walks the item through the datapath stages
    aea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and the two EV levels
    aea_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_item  (out_item)
    );

    // an accepted item keeps the input side busy while it is worked on
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not stalled after accepting an item");

    // a new result only comes from an item that was in flight
    a_result_from_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared with no item in flight");

    // 2^frac always lies in [1, 2) in Q1.15
    a_fraction_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.mult_fraction[15]
    ) else $error("mult_fraction below one");

endmodule
